// ----- src/qfr_pkg.sv -----
// Shared types, widths and the base score table for the queue family ranker.
// No dependencies; used by qfr_list and queue_family_top_k_ranker.
`default_nettype none

package qfr_pkg;

  // Field widths fixed by the item formats
  localparam int CAPS_W   = 3;
  localparam int QCOUNT_W = 10;
  localparam int RANK_W   = 5;
  localparam int LCOUNT_W = 3;
  localparam int BASE_W   = 8;
  // Largest score is 200 + 1023
  localparam int SCORE_W  = 11;
  localparam int NUM_CATS = 3;
  localparam int NUM_RANKS = 4;

  // Category codes, also the result order
  typedef enum logic [1:0] {
    CAT_COMPUTE  = 2'd0,
    CAT_TRANSFER = 2'd1,
    CAT_GRAPHICS = 2'd2
  } cat_t;

  // Base score of a capability key in one category
  function automatic logic [BASE_W-1:0] base_score(input logic [CAPS_W-1:0] caps,
                                                   input cat_t cat);
    logic [BASE_W-1:0] comp;
    logic [BASE_W-1:0] xfer;
    logic [BASE_W-1:0] gfx;
    comp = 8'd0;
    xfer = 8'd0;
    gfx  = 8'd0;
    unique case (caps)
      3'd0: begin comp = 8'd0;   xfer = 8'd0;   gfx = 8'd0;   end
      3'd1: begin comp = 8'd0;   xfer = 8'd200; gfx = 8'd0;   end
      3'd2: begin comp = 8'd200; xfer = 8'd0;   gfx = 8'd0;   end
      3'd3: begin comp = 8'd150; xfer = 8'd75;  gfx = 8'd0;   end
      3'd4: begin comp = 8'd0;   xfer = 8'd0;   gfx = 8'd100; end
      3'd5: begin comp = 8'd0;   xfer = 8'd50;  gfx = 8'd100; end
      3'd6: begin comp = 8'd50;  xfer = 8'd0;   gfx = 8'd100; end
      3'd7: begin comp = 8'd25;  xfer = 8'd25;  gfx = 8'd100; end
      default: begin comp = 8'd0; xfer = 8'd0; gfx = 8'd0; end
    endcase
    unique case (cat)
      CAT_COMPUTE:  return comp;
      CAT_TRANSFER: return xfer;
      CAT_GRAPHICS: return gfx;
      default:      return '0;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/qfr_list.sv -----
// One category's descending top-k list plus its saturating qualifier count.
// Depends on qfr_pkg for the score width.
`default_nettype none

module qfr_list #(
  parameter int DEPTH = 4,
  parameter int IDX_W = 4,
  parameter int CNT_W = 3
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 insert,
  input  wire logic                                 clear,
  input  wire logic [IDX_W-1:0]                     new_idx,
  input  wire logic [qfr_pkg::SCORE_W-1:0]          cand_score,
  output logic      [DEPTH-1:0]                     vld_next,
  output logic      [DEPTH-1:0][IDX_W-1:0]          idx_next,
  output logic      [CNT_W-1:0]                     count_next
);
  import qfr_pkg::*;

  logic [DEPTH-1:0]               vld;
  logic [DEPTH-1:0][IDX_W-1:0]    idx;
  logic [DEPTH-1:0][SCORE_W-1:0]  score;
  logic [CNT_W-1:0]               count;

  logic [DEPTH-1:0]               beat;
  logic [DEPTH-1:0][SCORE_W-1:0]  score_next;

  // Slot i is beaten when empty or strictly lower; valid slots lead, so beat is monotone
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      beat[i] = !vld[i] || (cand_score > score[i]);
    end
  end

  // Parallel compare and shift: first beaten slot takes the item, lower slots shift down
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      vld_next[i]   = vld[i];
      idx_next[i]   = idx[i];
      score_next[i] = score[i];
      if (insert && beat[i]) begin
        if (i == 0) begin
          vld_next[i]   = 1'b1;
          idx_next[i]   = new_idx;
          score_next[i] = cand_score;
        end else if (!beat[i-1]) begin
          vld_next[i]   = 1'b1;
          idx_next[i]   = new_idx;
          score_next[i] = cand_score;
        end else begin
          vld_next[i]   = vld[i-1];
          idx_next[i]   = idx[i-1];
          score_next[i] = score[i-1];
        end
      end
    end
  end

  // Qualifier count saturates at the list depth
  always_comb begin
    count_next = count;
    if (insert && (count < CNT_W'(DEPTH))) begin
      count_next = count + CNT_W'(1);
    end
  end

  // Valid bits and count cleared at reset and at end of run
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld   <= '0;
      count <= '0;
    end else begin
      vld   <= vld_next;
      count <= count_next;
    end
  end

  // Entry payload needs no reset; emptiness is carried by vld
  always_ff @(posedge clk) begin
    idx   <= idx_next;
    score <= score_next;
  end

endmodule

`default_nettype wire

// ----- src/queue_family_top_k_ranker.sv -----
// Results: the three results of a run (compute, transfer, graphics) appear in that
// order, each held until result_ready takes it, from the cycle after the last item is accepted.
// Throughput: one item per cycle; an item marked last waits while the previous
// run's results are draining, up to the cycle its graphics result is taken.
// Reset: rst (synchronous, active high) empties all lists, counts and results.
// Depends on qfr_pkg and qfr_list.
`default_nettype none

module queue_family_top_k_ranker #(
  parameter int TOP_DEPTH    = 4,
  parameter int MAX_FAMILIES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            item_valid,
  output logic                                 item_ready,
  input  wire logic [qfr_pkg::CAPS_W-1:0]      caps,
  input  wire logic [qfr_pkg::QCOUNT_W-1:0]    queue_count,
  input  wire logic                            last_family,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic      [1:0]                      category,
  output logic      [qfr_pkg::RANK_W-1:0]      rank0_index,
  output logic      [qfr_pkg::RANK_W-1:0]      rank1_index,
  output logic      [qfr_pkg::RANK_W-1:0]      rank2_index,
  output logic      [qfr_pkg::RANK_W-1:0]      rank3_index,
  output logic      [qfr_pkg::LCOUNT_W-1:0]    listed_count,
  output logic                                 last_result
);
  import qfr_pkg::*;

  localparam int IDX_W = (MAX_FAMILIES > 1) ? $clog2(MAX_FAMILIES) : 1;
  localparam int FC_W  = $clog2(MAX_FAMILIES + 1);
  localparam int CNT_W = $clog2(TOP_DEPTH + 1);

  logic             item_fire;
  logic             take;
  logic             run_end;
  logic [FC_W-1:0]  family_counter;

  logic [NUM_CATS-1:0]                           cat_insert;
  logic [NUM_CATS-1:0][SCORE_W-1:0]              cat_score;
  logic [NUM_CATS-1:0][TOP_DEPTH-1:0]            cat_vld;
  logic [NUM_CATS-1:0][TOP_DEPTH-1:0][IDX_W-1:0] cat_idx;
  logic [NUM_CATS-1:0][CNT_W-1:0]                cat_count;

  logic [NUM_CATS-1:0][NUM_RANKS-1:0][RANK_W-1:0] snap_rank_next;
  logic [NUM_CATS-1:0][NUM_RANKS-1:0][RANK_W-1:0] snap_rank;
  logic [NUM_CATS-1:0][LCOUNT_W-1:0]              snap_count;

  logic busy;
  cat_t cat_sel;

  // Handshake: only a run-ending item must wait for the result buffer,
  // which frees up as its graphics result is taken
  assign item_ready = !busy || !last_family ||
                      (result_ready && (cat_sel == CAT_GRAPHICS));
  assign item_fire  = item_valid && item_ready;
  assign take       = item_fire && (family_counter < FC_W'(MAX_FAMILIES));
  assign run_end    = item_fire && last_family;

  // Family numbering in arrival order
  always_ff @(posedge clk) begin
    if (rst || run_end) begin
      family_counter <= '0;
    end else if (take) begin
      family_counter <= family_counter + FC_W'(1);
    end
  end

  // One list per category
  for (genvar c = 0; c < NUM_CATS; c++) begin : g_cat
    logic [BASE_W-1:0] base;

    assign base          = base_score(caps, cat_t'(c));
    assign cat_insert[c] = take && (base != '0);
    assign cat_score[c]  = SCORE_W'(base) + SCORE_W'(queue_count);

    qfr_list #(
      .DEPTH (TOP_DEPTH),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_list (
      .clk        (clk),
      .rst        (rst),
      .insert     (cat_insert[c]),
      .clear      (run_end),
      .new_idx    (family_counter[IDX_W-1:0]),
      .cand_score (cat_score[c]),
      .vld_next   (cat_vld[c]),
      .idx_next   (cat_idx[c]),
      .count_next (cat_count[c])
    );

    // Rank fields read -1 for empty slots and for ranks past the depth
    for (genvar r = 0; r < NUM_RANKS; r++) begin : g_rank
      if (r < TOP_DEPTH) begin : g_live
        assign snap_rank_next[c][r] = cat_vld[c][r] ? RANK_W'(cat_idx[c][r]) : '1;
      end else begin : g_none
        assign snap_rank_next[c][r] = '1;
      end
    end
  end

  // Result buffer, loaded with the post-update lists of the last item
  always_ff @(posedge clk) begin
    if (run_end) begin
      snap_rank <= snap_rank_next;
      for (int c = 0; c < NUM_CATS; c++) begin
        snap_count[c] <= LCOUNT_W'(cat_count[c]);
      end
    end
  end

  // Result sequencer: compute, transfer, graphics
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      cat_sel <= CAT_COMPUTE;
    end else if (run_end) begin
      busy    <= 1'b1;
      cat_sel <= CAT_COMPUTE;
    end else if (busy && result_ready) begin
      if (cat_sel == CAT_GRAPHICS) begin
        busy <= 1'b0;
      end else begin
        cat_sel <= cat_t'(cat_sel + 2'd1);
      end
    end
  end

  // Output fields
  assign result_valid = busy;
  assign category     = cat_sel;
  assign rank0_index  = snap_rank[cat_sel][0];
  assign rank1_index  = snap_rank[cat_sel][1];
  assign rank2_index  = snap_rank[cat_sel][2];
  assign rank3_index  = snap_rank[cat_sel][3];
  assign listed_count = snap_count[cat_sel];
  assign last_result  = (cat_sel == CAT_GRAPHICS);

endmodule

`default_nettype wire
